/* src/eswm_pkg.sv */
// Package for the Euler world matrix block: fixed-point constants and helpers.
// Used by the sine cell, the sine unit and the top level.
`default_nettype none
package eswm_pkg;

   localparam logic signed [31:0] C1  = 32'sd1686629713;
   localparam logic signed [31:0] C3  = -32'sd693598668;
   localparam logic signed [31:0] C5  = 32'sd85569306;
   localparam logic signed [31:0] C7  = -32'sd5026995;
   localparam logic signed [31:0] C9  = 32'sd172272;
   localparam logic signed [31:0] C11 = -32'sd3864;
   localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

   // Number of slots in the sine chain: five Horner cells and one pass slot.
   localparam int unsigned POLY_CELLS = 6;

   // Signed multiply with a right shift, rounded half away from zero.
   function automatic logic signed [63:0] mul_rnd(input logic signed [32:0] a,
                                                  input logic signed [32:0] b,
                                                  input int unsigned sh);
      logic        neg;
      logic [32:0] ma;
      logic [32:0] mb;
      logic [65:0] p;
      neg = a[32] ^ b[32];
      ma  = a[32] ? 33'(-a) : 33'(a);
      mb  = b[32] ? 33'(-b) : 33'(b);
      p   = 66'(ma) * 66'(mb);
      p   = (p + (66'd1 << (sh - 1))) >> sh;
      return neg ? -64'(signed'(p[63:0])) : 64'(signed'(p[63:0]));
   endfunction

   // One sine pipeline slot: the argument and the running Horner term.
   typedef struct packed {
      logic               neg;
      logic signed [32:0] t;
      logic signed [32:0] t2;
      logic signed [32:0] p;
   } sin_slot_type;

endpackage
`default_nettype wire

/* src/eswm_sin_cell.sv */
// One Horner cell of the sine chain: p <= coef + t2*p, registered.
// Depends on eswm_pkg.
`default_nettype none
module eswm_sin_cell
   import eswm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] coef,
   input  wire sin_slot_type       d,
   output sin_slot_type            q
);
   sin_slot_type q_ff;
   sin_slot_type q_in;

   // Add the coefficient to the rounded product with t squared.
   always_comb begin
      q_in   = d;
      q_in.p = 33'(coef) + 33'(mul_rnd(d.t2, d.p, 30));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule
`default_nettype wire

/* src/eswm_sine.sv */
// Sine unit built as a chain of Horner cells; one angle enters per cycle while en is high.
// Depends on eswm_pkg and eswm_sin_cell.
`default_nettype none
module eswm_sine
   import eswm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [15:0]        angle,
   output logic signed [31:0]      sin_out
);
   sin_slot_type        s0_ff;
   sin_slot_type        s0_in;
   sin_slot_type        chain [POLY_CELLS];
   logic signed [31:0]  coefs [5];
   logic signed [31:0]  fin_ff;
   logic signed [63:0]  fin;
   logic [14:0]         r;

   assign coefs[0] = C9;
   assign coefs[1] = C7;
   assign coefs[2] = C5;
   assign coefs[3] = C3;
   assign coefs[4] = C1;

   // Quadrant fold and t squared.
   always_comb begin
      r = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      s0_in.neg = angle[15];
      s0_in.t   = 33'(signed'({1'b0, r, 16'd0}));
      s0_in.t2  = 33'(mul_rnd(s0_in.t, s0_in.t, 30));
      s0_in.p   = 33'(C11);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
      end
   end

   // Five Horner cells; the last slot just carries the term forward.
   genvar g;
   generate
      for (g = 0; g < POLY_CELLS; g++) begin : g_cell
         if (g < 5) begin : g_h
            eswm_sin_cell u_cell (
               .clock(clock), .en(en), .coef(coefs[g]),
               .d((g == 0) ? s0_ff : chain[(g == 0) ? 0 : g - 1]),
               .q(chain[g])
            );
         end else begin : g_pass
            sin_slot_type pass_ff;
            always_ff @(posedge clock) begin
               if (en) begin
                  pass_ff <= chain[g - 1];
               end
            end
            assign chain[g] = pass_ff;
         end
      end
   endgenerate

   // Final multiply by t, clamp and sign.
   always_comb begin
      fin = mul_rnd(chain[POLY_CELLS-1].t, chain[POLY_CELLS-1].p, 30);
      if (fin < 0) fin = 64'sd0;
      if (fin > 64'(Q30_ONE)) fin = 64'(Q30_ONE);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= chain[POLY_CELLS-1].neg ? -32'(fin) : 32'(fin);
      end
   end

   assign sin_out = fin_ff;
endmodule
`default_nettype wire

/* src/euler_scale_world_matrix_top.sv */
// Euler world matrix: one request per cycle sustained while the output is not stalled.
// Six sine chains (8 stages) feed a 3-stage product chain (pairs, triples,
// scaling); a stall freezes the whole pipeline. Reset clears valid bits only.
// Depends on eswm_pkg and eswm_sine.
`default_nettype none
module euler_scale_world_matrix_top
   import eswm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
   input  wire logic [191:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // m00 m01 m02 m10 m11 m12 m20 m21 m22 m30 m31 m32
   output logic [383:0]      rsp_tdata
);
   localparam int unsigned LAT = 11;
   localparam int unsigned SLAT = 8;

   logic en;
   logic [LAT-1:0] vld_ff;
   assign en = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end

   logic signed [31:0] sn [3];
   logic signed [31:0] cs [3];
   genvar a;
   generate
      for (a = 0; a < 3; a++) begin : g_ax
         eswm_sine u_s (.clock(clock), .en(en),
            .angle(req_tdata[16*a +: 16]), .sin_out(sn[a]));
         eswm_sine u_c (.clock(clock), .en(en),
            .angle(16'(req_tdata[16*a +: 16] + 16'h4000)), .sin_out(cs[a]));
      end
   endgenerate

   // Scale and position ride alongside the sine chains.
   logic [143:0] side_ff [LAT];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= req_tdata[191:48];
         for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // Stage A: pair products.
   logic signed [32:0] sxsy_ff, cxsy_ff, r0_ff, r1_ff, r5_ff, r8_ff, r2_ff;
   logic signed [32:0] cxsz_ff, cxcz_ff, sxsz_ff, sxcz_ff, czA_ff, szA_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sxsy_ff <= 33'(mul_rnd(33'(sn[0]), 33'(sn[1]), 30));
         cxsy_ff <= 33'(mul_rnd(33'(cs[0]), 33'(sn[1]), 30));
         r0_ff   <= 33'(mul_rnd(33'(cs[1]), 33'(cs[2]), 30));
         r1_ff   <= 33'(mul_rnd(33'(cs[1]), 33'(sn[2]), 30));
         r2_ff   <= -33'(sn[1]);
         r5_ff   <= 33'(mul_rnd(33'(sn[0]), 33'(cs[1]), 30));
         r8_ff   <= 33'(mul_rnd(33'(cs[0]), 33'(cs[1]), 30));
         cxsz_ff <= 33'(mul_rnd(33'(cs[0]), 33'(sn[2]), 30));
         cxcz_ff <= 33'(mul_rnd(33'(cs[0]), 33'(cs[2]), 30));
         sxsz_ff <= 33'(mul_rnd(33'(sn[0]), 33'(sn[2]), 30));
         sxcz_ff <= 33'(mul_rnd(33'(sn[0]), 33'(cs[2]), 30));
         czA_ff  <= 33'(cs[2]);
         szA_ff  <= 33'(sn[2]);
      end
   end

   // Stage B: triple products and sums.
   logic signed [33:0] rot_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff[0] <= 34'(r0_ff);
         rot_ff[1] <= 34'(r1_ff);
         rot_ff[2] <= 34'(r2_ff);
         rot_ff[3] <= 34'(mul_rnd(sxsy_ff, czA_ff, 30)) - 34'(cxsz_ff);
         rot_ff[4] <= 34'(mul_rnd(sxsy_ff, szA_ff, 30)) + 34'(cxcz_ff);
         rot_ff[5] <= 34'(r5_ff);
         rot_ff[6] <= 34'(mul_rnd(cxsy_ff, czA_ff, 30)) + 34'(sxsz_ff);
         rot_ff[7] <= 34'(mul_rnd(cxsy_ff, szA_ff, 30)) - 34'(sxcz_ff);
         rot_ff[8] <= 34'(r8_ff);
      end
   end

   // Stage C: scale, round to Q16, saturate.
   logic [287:0] mat_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 9; i++) begin
            logic signed [63:0] v;
            v = mul_rnd(33'(signed'(side_ff[SLAT+1][16*(i/3) +: 16])),
                        33'(rot_ff[i]), 26);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            mat_ff[32*i +: 32] <= v[31:0];
         end
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {side_ff[LAT-1][143:48], mat_ff};

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while the output is taken");
`endif
endmodule
`default_nettype wire
